// ===== design/rmq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion package
// Default widths and the codes for the branch that a word takes.
// ----------------------------------------------------------------------------
package rmq_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 30;

	typedef enum logic [1:0] {
		CASE_X     = 2'd0,
		CASE_Y     = 2'd1,
		CASE_Z     = 2'd2,
		CASE_TRACE = 2'd3
	} case_t;

endpackage
`default_nettype wire

// ===== design/rmq_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion channel interfaces
// Valid/ready channels for the matrix words and the quaternion words.
// ----------------------------------------------------------------------------
interface rmq_in_if #(parameter int DATA_WIDTH = 32);
	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

	modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		input ready);
	modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		output ready);
endinterface

interface rmq_out_if #(parameter int DATA_WIDTH = 32);
	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-1:0] qw, qx, qy, qz;
	logic                  status;

	modport source (output valid, qw, qx, qy, qz, status, input ready);
	modport sink (input valid, qw, qx, qy, qz, status, output ready);
endinterface
`default_nettype wire

// ===== design/rmq_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion front stage
// Picks the branch, forms the root argument and the three sum and difference terms.
// ----------------------------------------------------------------------------
module rmq_front #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 30,
	parameter int AW         = 34,
	parameter int TW         = 33
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       v_in,
	input  wire logic [8:0][DATA_WIDTH-1:0] m,
	output logic                            v_s1,
	output logic [AW-2:0]                   arg_s1,
	output logic [2:0][TW-1:0]              mag_s1,
	output logic [2:0]                      neg_s1,
	output rmq_pkg::case_t                  case_s1,
	output logic                            deg_s1
);
	import rmq_pkg::*;

	logic signed [AW-1:0] e [9];
	logic signed [AW-1:0] one, trace, arg, di, dj, dk;
	logic signed [AW-1:0] t [3];
	logic                 trace_pos, deg;
	case_t                cs;
	logic [1:0]           ii;

	always_comb begin
		for (int n = 0; n < 9; n++) begin
			e[n] = AW'($signed(m[n]));
		end
		one = {{(AW-1){1'b0}}, 1'b1} << FRAC_BITS;
		trace = e[0] + e[4] + e[8];
		trace_pos = !trace[AW-1] && (trace != '0);
		ii = 2'd0;
		if (e[4] > e[0]) begin
			ii = 2'd1;
		end
		if (e[8] > ((ii == 2'd1) ? e[4] : e[0])) begin
			ii = 2'd2;
		end
		case (ii)
			2'd0: begin
				cs = CASE_X;
				di = e[0]; dj = e[4]; dk = e[8];
				t[0] = e[3] + e[1]; t[1] = e[6] + e[2]; t[2] = e[7] - e[5];
			end
			2'd1: begin
				cs = CASE_Y;
				di = e[4]; dj = e[8]; dk = e[0];
				t[0] = e[7] + e[5]; t[1] = e[1] + e[3]; t[2] = e[2] - e[6];
			end
			default: begin
				cs = CASE_Z;
				di = e[8]; dj = e[0]; dk = e[4];
				t[0] = e[2] + e[6]; t[1] = e[5] + e[7]; t[2] = e[3] - e[1];
			end
		endcase
		if (trace_pos) begin
			cs = CASE_TRACE;
			arg = trace + one;
			t[0] = e[7] - e[5]; t[1] = e[2] - e[6]; t[2] = e[3] - e[1];
		end else begin
			arg = di - dj - dk + one;
		end
		deg = !trace_pos && (arg[AW-1] || (arg == '0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			arg_s1  <= deg ? '0 : arg[AW-2:0];
			case_s1 <= cs;
			deg_s1  <= deg;
			for (int l = 0; l < 3; l++) begin
				neg_s1[l] <= t[l][AW-1];
				mag_s1[l] <= t[l][AW-1] ? TW'(-t[l]) : TW'(t[l]);
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/rmq_sqrt_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion square root cell
// One restoring square root step: takes two radicand bits, yields one root bit.
// ----------------------------------------------------------------------------
module rmq_sqrt_cell #(
	parameter int RW     = 32,
	parameter int NN     = 64,
	parameter int SIDE_W = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              v_in,
	input  wire logic [RW+2:0]     rem_in,
	input  wire logic [RW-1:0]     root_in,
	input  wire logic [NN-1:0]     n_in,
	input  wire logic [SIDE_W-1:0] side_in,
	output logic                   v_out,
	output logic [RW+2:0]          rem_out,
	output logic [RW-1:0]          root_out,
	output logic [NN-1:0]          n_out,
	output logic [SIDE_W-1:0]      side_out
);
	logic          v_q;
	logic [RW+2:0] rem_q, sh, trial;
	logic [RW-1:0] root_q;
	logic [NN-1:0] n_q;
	logic [SIDE_W-1:0] side_q;
	logic          ge;

	always_comb begin
		sh    = {rem_in[RW:0], n_in[NN-1 -: 2]};
		trial = {1'b0, root_in, 2'b01};
		ge    = sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= ge ? sh - trial : sh;
			root_q <= {root_in[RW-2:0], ge};
			n_q    <= n_in << 2;
			side_q <= side_in;
		end
	end

	assign v_out    = v_q;
	assign rem_out  = rem_q;
	assign root_out = root_q;
	assign n_out    = n_q;
	assign side_out = side_q;

endmodule
`default_nettype wire

// ===== design/rmq_div_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion divider cell
// One restoring division step for three lanes that share a shifted divisor.
// ----------------------------------------------------------------------------
module rmq_div_cell #(
	parameter int CW     = 64,
	parameter int QW     = 32,
	parameter int SIDE_W = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              v_in,
	input  wire logic [CW-1:0]     dd_in,
	input  wire logic [2:0][CW-1:0] rem_in,
	input  wire logic [2:0][QW-1:0] q_in,
	input  wire logic [SIDE_W-1:0] side_in,
	output logic                   v_out,
	output logic [CW-1:0]          dd_out,
	output logic [2:0][CW-1:0]     rem_out,
	output logic [2:0][QW-1:0]     q_out,
	output logic [SIDE_W-1:0]      side_out
);
	logic              v_q;
	logic [CW-1:0]     dd_q;
	logic [2:0][CW-1:0] rem_q;
	logic [2:0][QW-1:0] q_q;
	logic [SIDE_W-1:0] side_q;
	logic [2:0]        ge;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			ge[l] = rem_in[l] >= dd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dd_q   <= dd_in >> 1;
			side_q <= side_in;
			for (int l = 0; l < 3; l++) begin
				rem_q[l] <= ge[l] ? rem_in[l] - dd_in : rem_in[l];
				q_q[l]   <= {q_in[l][QW-2:0], ge[l]};
			end
		end
	end

	assign v_out    = v_q;
	assign dd_out   = dd_q;
	assign rem_out  = rem_q;
	assign q_out    = q_q;
	assign side_out = side_q;

endmodule
`default_nettype wire

// ===== design/rotation_matrix_to_quaternion_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion unit
// Converts one 3x3 rotation matrix word into a unit quaternion word.
// ----------------------------------------------------------------------------
// The unit accepts one matrix word per cycle while it is not stalled and returns
// one quaternion word per matrix, in order. The root width is
// RW = (max(DATA_WIDTH+2, FRAC_BITS+1) + FRAC_BITS + 1) / 2. A word passes a
// front register, then a row of square root
// cells, one root bit each, then a row of divider cells, one quotient
// bit each for all three scaled terms. A single output register holds the
// word; the whole row stalls only while that word waits to be taken.
module rotation_matrix_to_quaternion_unit #(
	parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	rmq_in_if.sink   in_word,
	rmq_out_if.source out_word
);
	import rmq_pkg::*;

	localparam int DW  = DATA_WIDTH;
	localparam int AW  = ((DW + 2 > FRAC_BITS + 1) ? DW + 2 : FRAC_BITS + 1) + 1;
	localparam int TW  = DW + 1;
	localparam int NS  = AW - 1 + FRAC_BITS;
	localparam int RW  = (NS + 1) / 2;
	localparam int NN  = 2 * RW;
	localparam int NW  = TW + FRAC_BITS;
	localparam int CW  = (NW > RW + DW) ? NW : RW + DW;
	localparam int MW  = (RW > DW) ? RW : DW;
	localparam int SS  = 3 * TW + 6;
	localparam int SD  = DW + 6;

	logic en;
	logic out_valid_q;
	logic [DW-1:0] qw_q, qx_q, qy_q, qz_q;
	logic status_q;

	assign en = !out_valid_q || out_word.ready;
	assign in_word.ready = en;

	logic [8:0][DW-1:0] mat;
	assign mat = {in_word.m22, in_word.m21, in_word.m20, in_word.m12, in_word.m11,
		in_word.m10, in_word.m02, in_word.m01, in_word.m00};

	logic            v_s1, deg_s1;
	logic [AW-2:0]   arg_s1;
	logic [2:0][TW-1:0] mag_s1;
	logic [2:0]      neg_s1;
	case_t           case_s1;

	rmq_front #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS), .AW(AW), .TW(TW)) u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(in_word.valid), .m(mat),
		.v_s1(v_s1), .arg_s1(arg_s1), .mag_s1(mag_s1), .neg_s1(neg_s1),
		.case_s1(case_s1), .deg_s1(deg_s1)
	);

	logic          sv   [RW+1];
	logic [RW+2:0] srem [RW+1];
	logic [RW-1:0] sroot[RW+1];
	logic [NN-1:0] sn   [RW+1];
	logic [SS-1:0] sside[RW+1];

	assign sv[0]    = v_s1;
	assign srem[0]  = '0;
	assign sroot[0] = '0;
	assign sn[0]    = NN'({arg_s1, {FRAC_BITS{1'b0}}});
	assign sside[0] = {mag_s1, neg_s1, case_s1, deg_s1};

	for (genvar g = 0; g < RW; g++) begin : g_sqrt
		rmq_sqrt_cell #(.RW(RW), .NN(NN), .SIDE_W(SS)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.v_in(sv[g]), .rem_in(srem[g]), .root_in(sroot[g]), .n_in(sn[g]),
			.side_in(sside[g]),
			.v_out(sv[g+1]), .rem_out(srem[g+1]), .root_out(sroot[g+1]),
			.n_out(sn[g+1]), .side_out(sside[g+1])
		);
	end

	logic [RW-1:0] root;
	logic [MW-1:0] hz, pos_m;
	logic [DW-1:0] half;
	logic [2:0][TW-1:0] smag;
	logic [5:0] sflags;

	assign root  = sroot[RW];
	assign hz    = MW'(root >> 1);
	assign pos_m = MW'({1'b0, {(DW-1){1'b1}}});
	assign half  = (hz > pos_m) ? pos_m[DW-1:0] : hz[DW-1:0];
	assign smag  = sside[RW][SS-1 -: 3*TW];
	assign sflags = sside[RW][5:0];

	logic               dv   [DW+1];
	logic [CW-1:0]      ddd  [DW+1];
	logic [2:0][CW-1:0] drem [DW+1];
	logic [2:0][DW-1:0] dq   [DW+1];
	logic [SD-1:0]      dside[DW+1];

	assign dv[0]  = sv[RW];
	assign ddd[0] = CW'({root, 1'b0}) << (DW - 1);
	assign dq[0]  = '0;
	assign dside[0] = {half, sflags};
	for (genvar l = 0; l < 3; l++) begin : g_lane
		assign drem[0][l] = CW'({smag[l], {FRAC_BITS{1'b0}}});
	end

	for (genvar g = 0; g < DW; g++) begin : g_div
		rmq_div_cell #(.CW(CW), .QW(DW), .SIDE_W(SD)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.v_in(dv[g]), .dd_in(ddd[g]), .rem_in(drem[g]), .q_in(dq[g]),
			.side_in(dside[g]),
			.v_out(dv[g+1]), .dd_out(ddd[g+1]), .rem_out(drem[g+1]), .q_out(dq[g+1]),
			.side_out(dside[g+1])
		);
	end

	logic [DW-1:0] hf;
	logic [2:0]    fneg;
	case_t         fcase;
	logic          fdeg;
	logic [DW-1:0] val [3];
	logic [DW-1:0] nw, nx, ny, nz;

	always_comb begin
		hf    = dside[DW][SD-1 -: DW];
		fneg  = dside[DW][5:3];
		fcase = case_t'(dside[DW][2:1]);
		fdeg  = dside[DW][0];
		for (int l = 0; l < 3; l++) begin
			if (fneg[l]) begin
				val[l] = dq[DW][l][DW-1] ? {1'b1, {(DW-1){1'b0}}} :
					-{1'b0, dq[DW][l][DW-2:0]};
			end else begin
				val[l] = dq[DW][l][DW-1] ? {1'b0, {(DW-1){1'b1}}} :
					{1'b0, dq[DW][l][DW-2:0]};
			end
		end
		case (fcase)
			CASE_TRACE: begin
				nw = hf; nx = val[0]; ny = val[1]; nz = val[2];
			end
			CASE_X: begin
				nx = hf; ny = val[0]; nz = val[1]; nw = val[2];
			end
			CASE_Y: begin
				ny = hf; nz = val[0]; nx = val[1]; nw = val[2];
			end
			default: begin
				nz = hf; nx = val[0]; ny = val[1]; nw = val[2];
			end
		endcase
		if (fdeg) begin
			nw = '0; nx = '0; ny = '0; nz = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv[DW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qw_q     <= nw;
			qx_q     <= nx;
			qy_q     <= ny;
			qz_q     <= nz;
			status_q <= fdeg;
		end
	end

	assign out_word.valid  = out_valid_q;
	assign out_word.qw     = qw_q;
	assign out_word.qx     = qx_q;
	assign out_word.qy     = qy_q;
	assign out_word.qz     = qz_q;
	assign out_word.status = status_q;

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion unit testbench
// Sends directed and random matrix words through the unit, predicts every
// quaternion word with an integer model of the conversion, and compares each
// returned word field by field under several sender and receiver idle rates.
// ----------------------------------------------------------------------------
module tb;

	localparam int     DW        = rmq_pkg::DATA_WIDTH_DEF;
	localparam int     FB        = rmq_pkg::FRAC_BITS_DEF;
	localparam longint ONE_FX    = longint'(1) << FB;
	localparam longint POS_MAX   = (longint'(1) << (DW - 1)) - 1;
	localparam int     CYCLE_MAX = 400000;
	localparam int     DRAIN     = 80;

	typedef logic signed [DW-1:0] mat_t [9];

	typedef struct packed {
		logic signed [DW-1:0] w;
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic signed [DW-1:0] z;
		logic                 status;
	} quat_t;

	logic  clk;
	logic  arst_n;
	int    cycles;
	int    errors;
	int    send_idle_pct;
	int    recv_stall_pct;
	quat_t quat_expected[$];

	rmq_in_if  #(.DATA_WIDTH(DW)) in_if ();
	rmq_out_if #(.DATA_WIDTH(DW)) out_if ();

	rotation_matrix_to_quaternion_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_word  (in_if),
		.out_word (out_if)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic logic [63:0] int_sqrt(longint arg);
		logic [127:0] n;
		logic [127:0] t;
		logic [63:0]  root;
		n    = 128'(arg) << FB;
		root = '0;
		for (int b = 63; b >= 0; b--) begin
			t = 128'(root | (64'd1 << b));
			if (t * t <= n)
				root = t[63:0];
		end
		return root;
	endfunction

	function automatic logic signed [DW-1:0] half_of_root(logic [63:0] root);
		logic [63:0] h;
		h = root >> 1;
		return (h > 64'(POS_MAX)) ? DW'(POS_MAX) : DW'(h);
	endfunction

	function automatic logic signed [DW-1:0] scaled_diff(longint t, logic [63:0] root);
		logic [127:0] mag;
		logic [127:0] q;
		mag = (t < 0) ? 128'(-t) : 128'(t);
		q   = (mag << FB) / (128'(root) << 1);
		if (t < 0)
			return (q >= (128'd1 << (DW - 1))) ? {1'b1, {(DW-1){1'b0}}} : DW'(0 - q);
		return (q > 128'(POS_MAX)) ? DW'(POS_MAX) : DW'(q);
	endfunction

	function automatic quat_t matrix_to_quat(mat_t m);
		longint               e[3][3];
		longint               tr;
		longint               arg;
		logic [63:0]          root;
		logic signed [DW-1:0] v[4];
		int                   i;
		int                   j;
		int                   k;
		quat_t                r;
		for (int a = 0; a < 3; a++)
			for (int b = 0; b < 3; b++)
				e[a][b] = longint'(m[a * 3 + b]);
		for (int a = 0; a < 4; a++)
			v[a] = '0;
		r  = '0;
		tr = e[0][0] + e[1][1] + e[2][2];
		if (tr > 0) begin
			root = int_sqrt(tr + ONE_FX);
			v[0] = half_of_root(root);
			v[1] = scaled_diff(e[2][1] - e[1][2], root);
			v[2] = scaled_diff(e[0][2] - e[2][0], root);
			v[3] = scaled_diff(e[1][0] - e[0][1], root);
		end else begin
			i = 0;
			if (e[1][1] > e[0][0])
				i = 1;
			if (e[2][2] > e[i][i])
				i = 2;
			j   = (i + 1) % 3;
			k   = (j + 1) % 3;
			arg = e[i][i] - e[j][j] - e[k][k] + ONE_FX;
			if (arg <= 0) begin
				r.status = 1'b1;
			end else begin
				root     = int_sqrt(arg);
				v[1 + i] = half_of_root(root);
				v[1 + j] = scaled_diff(e[j][i] + e[i][j], root);
				v[1 + k] = scaled_diff(e[k][i] + e[i][k], root);
				v[0]     = scaled_diff(e[k][j] - e[j][k], root);
			end
		end
		r.w = v[0];
		r.x = v[1];
		r.y = v[2];
		r.z = v[3];
		return r;
	endfunction

	task automatic send_matrix(mat_t m);
		in_if.valid <= 1'b1;
		in_if.m00   <= m[0];
		in_if.m01   <= m[1];
		in_if.m02   <= m[2];
		in_if.m10   <= m[3];
		in_if.m11   <= m[4];
		in_if.m12   <= m[5];
		in_if.m20   <= m[6];
		in_if.m21   <= m[7];
		in_if.m22   <= m[8];
		do
			@(posedge clk);
		while (!in_if.ready);
		quat_expected.push_back(matrix_to_quat(m));
		if ($urandom_range(99) < send_idle_pct) begin
			in_if.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic check_field(string name, logic [DW-1:0] want, logic [DW-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		quat_t want;
		if (arst_n && out_if.valid && out_if.ready) begin
			if (quat_expected.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %h %h %h %h %b", $time,
					out_if.qw, out_if.qx, out_if.qy, out_if.qz, out_if.status);
				errors++;
			end else begin
				want = quat_expected.pop_front();
				check_field("qw", want.w, out_if.qw);
				check_field("qx", want.x, out_if.qx);
				check_field("qy", want.y, out_if.qy);
				check_field("qz", want.z, out_if.qz);
				check_field("status", DW'(want.status), DW'(out_if.status));
			end
		end
	end

	always @(posedge clk)
		out_if.ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_MAX) begin
			$display("[rotation_matrix_to_quaternion_unit] ERROR");
			$finish;
		end
	end

	function automatic mat_t diag_matrix(longint d0, longint d1, longint d2);
		mat_t m;
		foreach (m[a])
			m[a] = '0;
		m[0] = DW'(d0);
		m[4] = DW'(d1);
		m[8] = DW'(d2);
		return m;
	endfunction

	function automatic mat_t rotation_matrix();
		real  w;
		real  x;
		real  y;
		real  z;
		real  n;
		real  r[9];
		mat_t m;
		w = real'($signed($urandom_range(2000))) - 1000.0;
		x = real'($signed($urandom_range(2000))) - 1000.0;
		y = real'($signed($urandom_range(2000))) - 1000.0;
		z = real'($signed($urandom_range(2000))) - 1000.0;
		n = $sqrt(w * w + x * x + y * y + z * z);
		if (n == 0.0) begin
			w = 1.0;
			n = 1.0;
		end
		w = w / n;
		x = x / n;
		y = y / n;
		z = z / n;
		r[0] = 1.0 - 2.0 * (y * y + z * z);
		r[1] = 2.0 * (x * y - w * z);
		r[2] = 2.0 * (x * z + w * y);
		r[3] = 2.0 * (x * y + w * z);
		r[4] = 1.0 - 2.0 * (x * x + z * z);
		r[5] = 2.0 * (y * z - w * x);
		r[6] = 2.0 * (x * z - w * y);
		r[7] = 2.0 * (y * z + w * x);
		r[8] = 1.0 - 2.0 * (x * x + y * y);
		foreach (m[a])
			m[a] = DW'($rtoi(r[a] * real'(ONE_FX)) + $signed($urandom_range(64)) - 32);
		return m;
	endfunction

	task automatic test_rotations();
		send_matrix(diag_matrix(ONE_FX, ONE_FX, ONE_FX));
		send_matrix(diag_matrix(ONE_FX, -ONE_FX, -ONE_FX));
		send_matrix(diag_matrix(-ONE_FX, ONE_FX, -ONE_FX));
		send_matrix(diag_matrix(-ONE_FX, -ONE_FX, ONE_FX));
		repeat (4) send_matrix(rotation_matrix());
	endtask

	task automatic test_diagonal_ties();
		send_matrix(diag_matrix(0, 0, 0));
		send_matrix(diag_matrix(-ONE_FX, -ONE_FX, -ONE_FX));
		send_matrix(diag_matrix(0, 0, -ONE_FX));
		send_matrix(diag_matrix(-ONE_FX, 0, 0));
		send_matrix(diag_matrix(0, -ONE_FX, 0));
	endtask

	task automatic test_extremes();
		mat_t m;
		foreach (m[a])
			m[a] = {1'b0, {(DW-1){1'b1}}};
		send_matrix(m);
		foreach (m[a])
			m[a] = {1'b1, {(DW-1){1'b0}}};
		send_matrix(m);
		foreach (m[a])
			m[a] = (a % 2) ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		send_matrix(m);
		foreach (m[a])
			m[a] = '1;
		send_matrix(m);
	endtask

	task automatic test_saturation();
		mat_t m;
		m = diag_matrix(1, 0, 0);
		m[7] = {1'b0, {(DW-1){1'b1}}};
		m[5] = {1'b1, {(DW-1){1'b0}}};
		m[2] = {1'b1, {(DW-1){1'b0}}};
		m[6] = {1'b0, {(DW-1){1'b1}}};
		send_matrix(m);
		m = diag_matrix(0, 0, -1);
		m[1] = {1'b1, {(DW-1){1'b0}}};
		m[3] = {1'b1, {(DW-1){1'b0}}};
		m[7] = {1'b1, {(DW-1){1'b0}}};
		m[5] = {1'b0, {(DW-1){1'b1}}};
		send_matrix(m);
		m = diag_matrix(-ONE_FX + 1, -ONE_FX, -ONE_FX);
		m[3] = {1'b0, {(DW-1){1'b1}}};
		m[1] = {1'b0, {(DW-1){1'b1}}};
		send_matrix(m);
	endtask

	task automatic test_random_stream(int count, int idle_pct, int stall_pct);
		mat_t m;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) begin
			case ($urandom_range(9))
				0, 1: foreach (m[a]) m[a] = $urandom;
				2: begin
					foreach (m[a])
						m[a] = DW'(longint'($urandom_range(32'(3 * ONE_FX))) -
							3 * ONE_FX / 2);
				end
				default: m = rotation_matrix();
			endcase
			send_matrix(m);
		end
	endtask

	initial begin
		errors         = 0;
		cycles         = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		arst_n         = 1'b0;
		in_if.valid    = 1'b0;
		in_if.m00      = '0;
		in_if.m01      = '0;
		in_if.m02      = '0;
		in_if.m10      = '0;
		in_if.m11      = '0;
		in_if.m12      = '0;
		in_if.m20      = '0;
		in_if.m21      = '0;
		in_if.m22      = '0;
		out_if.ready   = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_rotations();
		test_diagonal_ties();
		test_extremes();
		test_saturation();
		test_random_stream(240, 0, 0);
		test_random_stream(240, 80, 0);
		test_random_stream(240, 0, 80);
		test_random_stream(240, 20, 20);
		in_if.valid <= 1'b0;
		while (quat_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (errors == 0) begin
			$display("[rotation_matrix_to_quaternion_unit] OK");
		end else begin
			$display("[rotation_matrix_to_quaternion_unit] ERROR");
		end
		$finish;
	end

endmodule
